[sv/assert_macros.svh]
// Assertion macros shared by the RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, switched off while reset is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[sv/las_pkg.sv]
// Launch angle search: shared constants, register indexes and the
// elaboration-time tangent generator used by the tangent ROM.
// No dependencies.
package las_pkg;

	localparam int unsigned FIRST_TENTHS   = 10;
	localparam int unsigned LAST_TENTHS    = 899;
	localparam int unsigned SWEEP_MAX      = LAST_TENTHS - FIRST_TENTHS + 1;
	localparam int unsigned SERIES_TERMS   = 12;
	localparam logic [63:0] PI_Q30         = 64'd3373259426;
	localparam logic [63:0] HALF_TURN_TENTHS = 64'd1800;

	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned REG_W      = 16;

	localparam logic [1:0] REG_TARGET    = 2'd0;
	localparam logic [1:0] REG_GRAVITY   = 2'd1;
	localparam logic [1:0] REG_TOLERANCE = 2'd2;

	localparam logic [REG_W-1:0] TARGET_RESET    = 16'd3050;
	localparam logic [REG_W-1:0] GRAVITY_RESET   = 16'd9810;
	localparam logic [REG_W-1:0] TOLERANCE_RESET = 16'd50;

	localparam int unsigned DROP_W = 63;
	localparam logic [DROP_W-1:0] DROP_CAP = 63'h4000_0000_0000_0000;

	// Restoring long division, only ever evaluated while building constants.
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		int i;
		r = '0;
		q = '0;
		for (i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// tan(t/10 degrees) in unsigned Q.frac, from Q30 Taylor series of sin and cos
	function automatic logic [63:0] tan_tenths(input int unsigned t, input int unsigned frac);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] st;
		logic [63:0] ct;
		logic [63:0] a;
		logic [63:0] num;
		longint s;
		longint c;
		int unsigned n;
		x  = (64'(t) * PI_Q30) / HALF_TURN_TENTHS;
		x2 = (x * x) >> 30;
		st = x;
		ct = 64'd1 << 30;
		s  = longint'(x);
		c  = longint'(64'd1 << 30);
		for (n = 1; n <= SERIES_TERMS; n++) begin
			a  = 64'(2 * n);
			st = udiv64((st * x2) >> 30, a * (a + 64'd1));
			ct = udiv64((ct * x2) >> 30, (a - 64'd1) * a);
			if (n[0]) begin
				s = s - longint'(st);
				c = c - longint'(ct);
			end else begin
				s = s + longint'(st);
				c = c + longint'(ct);
			end
		end
		if (s < 0) s = 0;
		if (c < 1) c = 1;
		num = (64'(s) << frac) + (64'(c) >> 1);
		return udiv64(num, 64'(c));
	endfunction

endpackage

[sv/las_tan_rom.sv]
// Tangent ROM, one entry per tenth of a degree from 1.0 upwards, registered read.
// Contents are built at elaboration from las_pkg::tan_tenths.
module las_tan_rom #(
	parameter int NUM_ENTRIES = 890,
	parameter int FRAC_BITS   = 16
) (
	input  logic                           clk,
	input  logic [$clog2(NUM_ENTRIES)-1:0] addr,
	output logic [FRAC_BITS+9:0]           rd_data
);

	localparam int TW = FRAC_BITS + 10;

	logic [TW-1:0] rom_w [NUM_ENTRIES];
	logic [TW-1:0] rd_data_q;

	for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_entry
		localparam logic [63:0] TanVal =
			las_pkg::tan_tenths(las_pkg::FIRST_TENTHS + g, FRAC_BITS);
		assign rom_w[g] = TanVal[TW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_data_q <= rom_w[addr];
	end

	assign rd_data = rd_data_q;

endmodule

[sv/las_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle, NUM_W quotient bits a division.
// Standalone; used by the top level to form the per-request drop factor.
module las_div #(
	parameter int NUM_W = 64,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CW = $clog2(NUM_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// numerator shifts out of the top of quo_q while quotient bits enter below
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[sv/launch_angle_search_unit.sv]
// Launch angle search unit: sweeps tenth-degree launch angles for the best height match.
// The drop factor comes from the 64-step divider, then one angle per cycle is swept
// through an 8-stage evaluation pipeline; a zero-speed request skips the division
// and the sweep and answers with no match.
// One request at a time; the next is taken while the previous result waits.
// Async active-low reset clears control and loads the register reset values.
module launch_angle_search_unit #(
	parameter int NUM_ANGLES    = 890,
	parameter int TAN_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [las_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [las_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [las_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [15:0]                      distance_mm,
	input  logic [15:0]                      shooter_height_mm,
	input  logic [15:0]                      launch_speed_mm_s,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic                             found,
	output logic [9:0]                       angle_tenths,
	output logic [15:0]                      miss_mm
);

	localparam int USED    = (NUM_ANGLES < las_pkg::SWEEP_MAX) ? NUM_ANGLES
	                                                             : las_pkg::SWEEP_MAX;
	localparam int AW      = $clog2(USED);
	localparam int F       = TAN_FRAC_BITS;
	localparam int TW      = F + 10;
	localparam int SEC_W   = F + 21;
	localparam int RSH     = (F >= 16) ? F - 16 : 0;
	localparam int LSH     = (F < 16) ? 16 - F : 0;
	localparam int RISE_FW = 16 + TW + LSH;
	localparam int RISE_W  = 42;
	localparam int RH_W    = 44;
	localparam int DEN_W   = 33;
	localparam int K_W     = 64;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_PREP  = 7'b0000010,
		ST_LOAD  = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_SWEEP = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic          vld;
		logic          last;
		logic [AW-1:0] idx;
	} ctl_t;

	// configuration
	logic [15:0] target_q;
	logic [15:0] gravity_q;
	logic [15:0] tol_q;
	logic        cfg_wr;

	// sequencer
	state_t        state_q;
	state_t        state_d;
	logic [AW-1:0] idx_q;
	logic          req_accept;
	logic          rsp_load;
	logic          issue;
	logic          idx_last;
	logic          sweep_end;
	logic          rsp_valid_q;

	// per-request values
	logic [15:0]        d_q;
	logic [15:0]        sh_q;
	logic [15:0]        v_q;
	logic [31:0]        gd_q;
	logic [31:0]        vsq_q;
	logic signed [32:0] hd_q;
	logic [K_W-1:0]     k_q;
	logic               div_start;
	logic               div_done;
	logic [K_W-1:0]     div_quot;
	logic [K_W-1:0]     div_num;
	logic [47:0]        q_mul;

	// sweep pipeline
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;
	logic [TW-1:0]          tan_s1;
	logic [2*TW-1:0]        sq_s2;
	logic [RISE_W-1:0]      rise_s2;
	logic [RISE_FW-1:0]     rise_full;
	logic [SEC_W-1:0]       sec2_s3;
	logic signed [RH_W-1:0] rh_s3, rh_s4, rh_s5, rh_s6, rh_s7;
	logic [63:0]            sec64;
	logic [63:0]            pp00_s4, pp01_s4, pp10_s4, pp11_s4;
	logic [64:0]            mid_s5;
	logic [127:0]           lohi_s5;
	logic [127:0]           prod_s6;
	logic [127:0]           pshift;
	logic [las_pkg::DROP_W-1:0] drop_s7;
	logic signed [63:0]     err_e;
	logic [63:0]            err_abs;
	logic                   hit_s8;
	logic [31:0]            err_s8;
	logic [31:0]            tol32;

	// best match
	logic          best_found_q;
	logic [31:0]   best_err_q;
	logic [AW-1:0] best_idx_q;
	logic          found_q;
	logic [9:0]    angle_q;
	logic [15:0]   miss_q;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= las_pkg::TARGET_RESET;
			gravity_q <= las_pkg::GRAVITY_RESET;
			tol_q     <= las_pkg::TOLERANCE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				las_pkg::REG_TARGET:    target_q  <= pwdata[15:0];
				las_pkg::REG_GRAVITY:   gravity_q <= pwdata[15:0];
				las_pkg::REG_TOLERANCE: tol_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			las_pkg::REG_TARGET:    prdata = {16'd0, target_q};
			las_pkg::REG_GRAVITY:   prdata = {16'd0, gravity_q};
			las_pkg::REG_TOLERANCE: prdata = {16'd0, tol_q};
			default:                prdata = '0;
		endcase
	end

	// ---------------- sequencer ----------------
	assign req_ready  = (state_q == ST_IDLE);
	assign req_accept = req_valid & req_ready;
	assign rsp_load   = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign issue      = (state_q == ST_SWEEP);
	assign idx_last   = (idx_q == AW'(USED - 1));
	assign sweep_end  = ctl_s8.vld && ctl_s8.last;
	assign div_start  = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (req_accept)
				state_d = (launch_speed_mm_s == '0) ? ST_DONE : ST_PREP;
			ST_PREP:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_DIV;
			ST_DIV:   if (div_done) state_d = ST_SWEEP;
			ST_SWEEP: if (idx_last) state_d = ST_DRAIN;
			ST_DRAIN: if (sweep_end) state_d = ST_DONE;
			ST_DONE:  if (rsp_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			rsp_valid_q  <= 1'b0;
			best_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV) idx_q <= '0;
			else if (issue) idx_q <= idx_q + 1'b1;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
			if (req_accept) begin
				best_found_q <= 1'b0;
			end else if (ctl_s8.vld && hit_s8) begin
				best_found_q <= 1'b1;
			end
		end
	end

	// per-request set-up: k = g*D^2*2^16 / (2*v^2)
	always_ff @(posedge clk) begin
		if (req_accept) begin
			d_q  <= distance_mm;
			sh_q <= shooter_height_mm;
			v_q  <= launch_speed_mm_s;
		end
		if (state_q == ST_PREP) begin
			gd_q  <= 32'(gravity_q) * 32'(d_q);
			vsq_q <= 32'(v_q) * 32'(v_q);
			hd_q  <= ($signed({17'd0, target_q}) - $signed({17'd0, sh_q})) <<< 16;
		end
		if ((state_q == ST_DIV) && div_done) k_q <= div_quot;
	end

	assign q_mul   = 48'(gd_q) * 48'(d_q);
	assign div_num = {q_mul, 16'd0};

	las_div #(
		.NUM_W(K_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   ({vsq_q, 1'b0}),
		.done  (div_done),
		.quot  (div_quot)
	);

	// ---------------- sweep pipeline ----------------
	las_tan_rom #(
		.NUM_ENTRIES(USED),
		.FRAC_BITS  (F)
	) u_rom (
		.clk    (clk),
		.addr   (idx_q),
		.rd_data(tan_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else begin
			ctl_s1 <= '{vld: issue, last: idx_last, idx: idx_q};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	// rise = D*tan brought to Q16
	assign rise_full = ((RISE_FW'(d_q) * RISE_FW'(tan_s1)) >> RSH) << LSH;
	assign sec64     = 64'(sec2_s3);
	assign pshift    = prod_s6 >> F;
	assign tol32     = {tol_q, 16'd0};

	always_ff @(posedge clk) begin
		sq_s2   <= (2*TW)'(tan_s1) * (2*TW)'(tan_s1);
		rise_s2 <= rise_full[RISE_W-1:0];

		sec2_s3 <= (SEC_W'(1) << F) + SEC_W'(sq_s2 >> F);
		rh_s3   <= $signed({2'b00, rise_s2}) - $signed({{(RH_W-33){hd_q[32]}}, hd_q});

		// k*sec2 as four 32x32 partial products
		pp00_s4 <= 64'(k_q[31:0])  * 64'(sec64[31:0]);
		pp01_s4 <= 64'(k_q[31:0])  * 64'(sec64[63:32]);
		pp10_s4 <= 64'(k_q[63:32]) * 64'(sec64[31:0]);
		pp11_s4 <= 64'(k_q[63:32]) * 64'(sec64[63:32]);
		rh_s4   <= rh_s3;

		mid_s5  <= 65'(pp01_s4) + 65'(pp10_s4);
		lohi_s5 <= {pp11_s4, pp00_s4};
		rh_s5   <= rh_s4;

		prod_s6 <= lohi_s5 + ({63'd0, mid_s5} << 32);
		rh_s6   <= rh_s5;

		drop_s7 <= (pshift > 128'(las_pkg::DROP_CAP)) ? las_pkg::DROP_CAP
		                                              : pshift[las_pkg::DROP_W-1:0];
		rh_s7   <= rh_s6;
	end

	assign err_e   = $signed({{(64-RH_W){rh_s7[RH_W-1]}}, rh_s7})
	                 - $signed({1'b0, drop_s7});
	assign err_abs = err_e[63] ? 64'(-err_e) : 64'(err_e);

	// hit_s8 folds the tolerance check and the strictly-better check
	always_ff @(posedge clk) begin
		err_s8 <= err_abs[31:0];
		hit_s8 <= 1'b0;
		if (err_abs <= {32'd0, tol32}) begin
			if (!best_found_q) hit_s8 <= 1'b1;
			else if (err_abs[31:0] < best_err_q) hit_s8 <= 1'b1;
		end
	end

	// ---------------- best match and result ----------------
	always_ff @(posedge clk) begin
		if (ctl_s8.vld && hit_s8 && (!best_found_q || err_s8 < best_err_q)) begin
			best_err_q <= err_s8;
			best_idx_q <= ctl_s8.idx;
		end
		if (rsp_load) begin
			found_q <= best_found_q;
			angle_q <= best_found_q ? 10'(las_pkg::FIRST_TENTHS) + 10'(best_idx_q) : '0;
			miss_q  <= best_found_q ? best_err_q[31:16] : '0;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign found        = found_q;
	assign angle_tenths = angle_q;
	assign miss_mm      = miss_q;

	// ---------------- checks ----------------
`include "assert_macros.svh"

	`ASSERT_CLK(a_idle_pipe_empty, req_ready |-> !(ctl_s1.vld || ctl_s4.vld || ctl_s8.vld), "request taken while sweep in flight")
	`ASSERT_CLK(a_found_range, (rsp_valid && found) |-> (angle_tenths >= 10'(las_pkg::FIRST_TENTHS) && angle_tenths <= 10'(las_pkg::LAST_TENTHS) && miss_mm <= tol_q), "found result out of range")
	`ASSERT_CLK(a_not_found_zero, (rsp_valid && !found) |-> (angle_tenths == '0 && miss_mm == '0), "empty result not zeroed")
	`ASSERT_NEVER(a_div_done_state, div_done && (state_q != ST_DIV), "divider finished outside DIV")

endmodule
